>>> sv/lced_pkg.sv
package lced_pkg;

    // width of a window fill count (window_length is 7 bits)
    localparam int CNT_W = 7;

    // fractional bits of the squared correlation (Q1.15 squared)
    localparam int FRAC2 = 30;
    localparam int DIV_STEPS = FRAC2 + 1;
    localparam int SQRT_STEPS = FRAC2 / 2 + 1;

    // input commands, carried on tuser
    localparam logic [1:0] CMD_ACT  = 2'd0;
    localparam logic [1:0] CMD_SENT = 2'd1;
    localparam logic [1:0] CMD_CLR  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_WLEN = 2'd0;
    localparam logic [1:0] REG_MIN  = 2'd1;
    localparam logic [1:0] REG_LAG  = 2'd2;
    localparam logic [1:0] REG_THR  = 2'd3;

    typedef enum logic [1:0] {
        WOP_MUL  = 2'd0,
        WOP_SUB  = 2'd1,
        WOP_DIV  = 2'd2,
        WOP_SQRT = 2'd3
    } wide_op_t;

    typedef struct packed {
        logic     start;
        wide_op_t op;
    } wide_req_t;

    typedef enum logic [1:0] {
        MAC_XX = 2'd0,
        MAC_YY = 2'd1,
        MAC_XY = 2'd2
    } mac_sel_t;

    typedef struct packed {
        logic     clr;
        logic     step;
        mac_sel_t sel;
    } mac_ctl_t;

    typedef enum logic [3:0] {
        CS_CSXX = 4'd0,
        CS_SXSX = 4'd1,
        CS_A    = 4'd2,
        CS_CSYY = 4'd3,
        CS_SYSY = 4'd4,
        CS_B    = 4'd5,
        CS_CSXY = 4'd6,
        CS_SXSY = 4'd7,
        CS_M    = 4'd8,
        CS_AB   = 4'd9,
        CS_MM   = 4'd10,
        CS_DIV  = 4'd11,
        CS_SQRT = 4'd12
    } calc_step_t;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_EVAL  = 9'b000000010,
        ST_LAG   = 9'b000000100,
        ST_ACC   = 9'b000001000,
        ST_FLUSH = 9'b000010000,
        ST_CALC  = 9'b000100000,
        ST_CMP   = 9'b001000000,
        ST_FIN   = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

endpackage

>>> sv/lced_ring.sv
module lced_ring #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sv/lced_mac.sv
module lced_mac #(
    parameter int SB = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lced_pkg::mac_ctl_t                  ctl,
    input  logic [SB-1:0]                       x_raw,
    input  logic [SB-1:0]                       y_raw,
    output logic [SB+lced_pkg::CNT_W-1:0]       sx,
    output logic [SB+lced_pkg::CNT_W-1:0]       sy,
    output logic [2*SB+lced_pkg::CNT_W-1:0]     sxx,
    output logic [2*SB+lced_pkg::CNT_W-1:0]     syy,
    output logic [2*SB+lced_pkg::CNT_W-1:0]     sxy
);

    localparam int SW = SB + lced_pkg::CNT_W;
    localparam int QW = 2 * SB + lced_pkg::CNT_W;

    logic [SB-1:0]      xo, yo, mul_a, mul_b;
    logic [2*SB-1:0]    prod;
    logic [2*SB-1:0]    prod_reg;
    logic               pend_reg;
    lced_pkg::mac_sel_t psel_reg;
    logic [SW-1:0]      sx_reg, sy_reg;
    logic [QW-1:0]      sxx_reg, syy_reg, sxy_reg;

    // offset binary: correlation does not change under a shift
    assign xo = {~x_raw[SB-1], x_raw[SB-2:0]};
    assign yo = {~y_raw[SB-1], y_raw[SB-2:0]};

    always_comb begin
        mul_a = (ctl.sel == lced_pkg::MAC_YY) ? yo : xo;
        mul_b = (ctl.sel == lced_pkg::MAC_XX) ? xo : yo;
    end

    assign prod = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clr) begin
            pend_reg <= 1'b0;
            sx_reg   <= '0;
            sy_reg   <= '0;
            sxx_reg  <= '0;
            syy_reg  <= '0;
            sxy_reg  <= '0;
        end else begin
            pend_reg <= ctl.step;
            if (ctl.step) begin
                prod_reg <= prod;
                psel_reg <= ctl.sel;
                if (ctl.sel == lced_pkg::MAC_XX) begin
                    sx_reg <= sx_reg + SW'(xo);
                end
                if (ctl.sel == lced_pkg::MAC_YY) begin
                    sy_reg <= sy_reg + SW'(yo);
                end
            end
            if (pend_reg) begin
                unique case (psel_reg)
                    lced_pkg::MAC_XX: sxx_reg <= sxx_reg + QW'(prod_reg);
                    lced_pkg::MAC_YY: syy_reg <= syy_reg + QW'(prod_reg);
                    lced_pkg::MAC_XY: sxy_reg <= sxy_reg + QW'(prod_reg);
                    default: ;
                endcase
            end
        end
    end

    assign sx  = sx_reg;
    assign sy  = sy_reg;
    assign sxx = sxx_reg;
    assign syy = syy_reg;
    assign sxy = sxy_reg;

endmodule

>>> sv/lced_wide.sv
module lced_wide #(
    parameter int WW = 93
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lced_pkg::wide_req_t req,
    input  logic [WW-1:0]       a,
    input  logic [WW-1:0]       b,
    output logic                done,
    output logic [WW-1:0]       res,
    output logic                neg
);

    logic                busy_reg, done_reg, neg_reg;
    lced_pkg::wide_op_t  op_reg;
    logic [WW-1:0]       acc_reg, x_reg, y_reg, res_reg;
    logic [4:0]          cnt_reg;

    logic [WW-1:0]       add_l, add_r;
    logic                add_sub;
    logic [WW:0]         sum;
    logic                ge;
    logic [31:0]         trial, root_next;
    logic [WW-1:0]       rem;

    // sqrt trial value: root so far plus the current bit
    assign trial = x_reg[31:0] + y_reg[31:0];

    always_comb begin
        unique case (op_reg)
            lced_pkg::WOP_MUL: begin
                add_l = acc_reg; add_r = x_reg; add_sub = 1'b0;
            end
            lced_pkg::WOP_SUB: begin
                add_l = x_reg; add_r = y_reg; add_sub = 1'b1;
            end
            lced_pkg::WOP_DIV: begin
                add_l = acc_reg; add_r = y_reg; add_sub = 1'b1;
            end
            lced_pkg::WOP_SQRT: begin
                add_l = acc_reg; add_r = WW'(trial); add_sub = 1'b1;
            end
        endcase
    end

    // the shared adder; bit WW is the no-borrow flag when subtracting
    assign sum = {1'b0, add_l} + {1'b0, (add_sub ? ~add_r : add_r)} + (WW+1)'(add_sub);
    assign ge  = sum[WW];
    assign rem = ge ? sum[WW-1:0] : acc_reg;
    assign root_next = ge ? ((x_reg[31:0] >> 1) + y_reg[31:0]) : (x_reg[31:0] >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                op_reg   <= req.op;
                busy_reg <= 1'b1;
                neg_reg  <= 1'b0;
                cnt_reg  <= '0;
                unique case (req.op)
                    lced_pkg::WOP_MUL: begin
                        acc_reg <= '0; x_reg <= a; y_reg <= b;
                    end
                    lced_pkg::WOP_SUB: begin
                        x_reg <= a; y_reg <= b;
                    end
                    lced_pkg::WOP_DIV: begin
                        acc_reg <= a; x_reg <= '0; y_reg <= b;
                    end
                    lced_pkg::WOP_SQRT: begin
                        acc_reg <= a; x_reg <= '0;
                        y_reg   <= WW'(1) << lced_pkg::FRAC2;
                    end
                endcase
            end else if (busy_reg) begin
                unique case (op_reg)
                    lced_pkg::WOP_MUL: begin
                        if (y_reg == '0) begin
                            res_reg  <= acc_reg;
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end else begin
                            if (y_reg[0]) begin
                                acc_reg <= sum[WW-1:0];
                            end
                            x_reg <= x_reg << 1;
                            y_reg <= y_reg >> 1;
                        end
                    end
                    lced_pkg::WOP_SUB: begin
                        if (ge) begin
                            res_reg  <= sum[WW-1:0];
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end else begin
                            x_reg   <= y_reg;
                            y_reg   <= x_reg;
                            neg_reg <= 1'b1;
                        end
                    end
                    lced_pkg::WOP_DIV: begin
                        acc_reg <= rem << 1;
                        x_reg   <= {x_reg[WW-2:0], ge};
                        cnt_reg <= cnt_reg + 5'd1;
                        if (cnt_reg == 5'(lced_pkg::DIV_STEPS - 1)) begin
                            res_reg  <= {x_reg[WW-2:0], ge};
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                    lced_pkg::WOP_SQRT: begin
                        if (ge) begin
                            acc_reg <= sum[WW-1:0];
                        end
                        x_reg   <= WW'(root_next);
                        y_reg   <= y_reg >> 2;
                        cnt_reg <= cnt_reg + 5'd1;
                        if (cnt_reg == 5'(lced_pkg::SQRT_STEPS - 1)) begin
                            res_reg  <= WW'(root_next);
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;
    assign neg  = neg_reg;

endmodule

>>> sv/lagged_correlation_episode_detector_unit.sv
// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   s_tdata: sample_value; s_tuser: cmd
// m_        out  m_tvalid/m_tready   m_tdata: score, lag, fired, in_episode, evaluated
// cfg_      in   cfg_wr_en           cfg_index, cfg_wdata
//
// An item that does not evaluate goes from the done state into the output register,
// and the next item can be accepted in the same cycle that its result is offered on m_.
// An evaluating item runs a lag sweep: for each lag with an overlap of at least two
// samples, the product accumulator steps through the aligned samples, then the one
// wide adder runs a chain of shift-add multiplies, a 31-step divide and a 16-step root
// (cut short after the variance terms if either is zero). Reset is synchronous;
// the sample rings need no clearing pass, only their heads and fill counts reset.
// A finished result waits in the output register; the next item is taken once the
// current one has left the sequencer. Input is held off during a register write.
module lagged_correlation_episode_detector_unit #(
    parameter int WINDOW_DEPTH = 64,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // sample_value
    input  logic [1:0]                          s_tuser,   // cmd
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // score[15:0], lag[21:16], fired[22], in_episode[23], evaluated[24]
    output logic [31:0]                         m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [1:0]                          cfg_index,
    input  logic [15:0]                         cfg_wdata
);

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int CW    = lced_pkg::CNT_W;
    localparam int PW    = ((IDX_W > CW) ? IDX_W : CW) + 1;
    localparam int SW    = SAMPLE_BITS + CW;
    localparam int QW    = 2 * SAMPLE_BITS + CW;
    localparam int AW    = 2 * SAMPLE_BITS + 2 * CW;
    localparam int WW    = 2 * AW + 1;

    // configuration
    logic [6:0]        wl_reg, ms_reg;
    logic [5:0]        ll_reg;
    logic signed [15:0] thr_reg;

    // window and result state
    logic [IDX_W-1:0]  ahead_reg, shead_reg;
    logic [CW-1:0]     acnt_reg, scnt_reg;
    logic [15:0]       peak_reg;
    logic [5:0]        plag_reg;
    logic              ep_reg;

    // sequencer
    lced_pkg::state_t     state_reg, state_next;
    lced_pkg::calc_step_t step_reg;
    logic              iss_reg;
    logic [CW-1:0]     n_reg, c_reg, i_reg;
    logic [5:0]        top_reg, lag_reg;
    logic [1:0]        ph_reg;
    logic [IDX_W-1:0]  aptr_reg, sptr_reg;
    logic [15:0]       bmag_reg, qv_reg;
    logic              bneg_reg, neg_reg;
    logic [5:0]        blag_reg;
    logic [WW-1:0]     t1_reg, t2_reg, ab_reg;
    logic [AW-1:0]     a_reg, b_reg, m_reg;
    logic              fired_reg, evald_reg;
    logic              m_tvalid_reg;
    logic [31:0]       m_tdata_reg;

    logic              accept;
    logic [PW-1:0]     lim;
    logic              lim_zero;
    logic [SAMPLE_BITS-1:0] a_rd, s_rd;
    logic [SW-1:0]     sx, sy;
    logic [QW-1:0]     sxx, syy, sxy;
    lced_pkg::mac_ctl_t  mac_ctl;
    lced_pkg::wide_req_t w_req;
    lced_pkg::wide_op_t  w_op;
    logic [WW-1:0]     w_a, w_b, w_res;
    logic              w_done, w_neg;
    logic [CW-1:0]     n_min, nm1, c_cur;
    logic [5:0]        top_cur;
    logic [15:0]       sat, score;
    logic              out_free;

    // slot that lies k entries before head, modulo the ring depth
    function automatic logic [IDX_W-1:0] slot_back(input logic [IDX_W-1:0] h,
                                                   input logic [CW-1:0] k);
        logic [PW-1:0] hh, kk, r;
        hh = PW'(h);
        kk = PW'(k);
        r = (hh >= kk) ? (hh - kk) : (hh + PW'(WINDOW_DEPTH) - kk);
        return r[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] h);
        return (h == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : h + IDX_W'(1);
    endfunction

    // hold off input in reset, while the sequencer is busy and while a register is written
    assign s_tready = aresetn && (state_reg == lced_pkg::ST_IDLE) && !cfg_wr_en;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // effective window length
    assign lim = (PW'(wl_reg) > PW'(WINDOW_DEPTH)) ? PW'(WINDOW_DEPTH) : PW'(wl_reg);
    assign lim_zero = (lim == '0);

    assign n_min   = (acnt_reg < scnt_reg) ? acnt_reg : scnt_reg;
    assign nm1     = (n_min == '0) ? '0 : n_min - CW'(1);
    assign top_cur = (CW'(ll_reg) < nm1) ? ll_reg : nm1[5:0];
    assign c_cur   = n_reg - CW'(lag_reg);

    lced_ring #(.DEPTH(WINDOW_DEPTH), .WIDTH(SAMPLE_BITS)) u_act_ring (
        .aclk    (aclk),
        .wr_en   (accept && s_tuser == lced_pkg::CMD_ACT && !lim_zero),
        .wr_addr (ahead_reg),
        .wr_data (s_tdata[SAMPLE_BITS-1:0]),
        .rd_addr (aptr_reg),
        .rd_data (a_rd)
    );

    lced_ring #(.DEPTH(WINDOW_DEPTH), .WIDTH(SAMPLE_BITS)) u_sent_ring (
        .aclk    (aclk),
        .wr_en   (accept && s_tuser == lced_pkg::CMD_SENT && !lim_zero),
        .wr_addr (shead_reg),
        .wr_data (s_tdata[SAMPLE_BITS-1:0]),
        .rd_addr (sptr_reg),
        .rd_data (s_rd)
    );

    // ring data is valid in phases 1..3 of each sample
    always_comb begin
        mac_ctl.clr  = (state_reg == lced_pkg::ST_LAG);
        mac_ctl.step = (state_reg == lced_pkg::ST_ACC) && (ph_reg != 2'd0);
        unique case (ph_reg)
            2'd1:    mac_ctl.sel = lced_pkg::MAC_XX;
            2'd2:    mac_ctl.sel = lced_pkg::MAC_YY;
            default: mac_ctl.sel = lced_pkg::MAC_XY;
        endcase
    end

    lced_mac #(.SB(SAMPLE_BITS)) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .x_raw   (a_rd),
        .y_raw   (s_rd),
        .sx      (sx),
        .sy      (sy),
        .sxx     (sxx),
        .syy     (syy),
        .sxy     (sxy)
    );

    // operand selection for each step of the per-lag calculation
    always_comb begin
        w_op = lced_pkg::WOP_MUL;
        w_a  = '0;
        w_b  = '0;
        unique case (step_reg)
            lced_pkg::CS_CSXX: begin w_a = WW'(c_reg); w_b = WW'(sxx); end
            lced_pkg::CS_SXSX: begin w_a = WW'(sx);    w_b = WW'(sx);  end
            lced_pkg::CS_A: begin
                w_op = lced_pkg::WOP_SUB; w_a = t1_reg; w_b = t2_reg;
            end
            lced_pkg::CS_CSYY: begin w_a = WW'(c_reg); w_b = WW'(syy); end
            lced_pkg::CS_SYSY: begin w_a = WW'(sy);    w_b = WW'(sy);  end
            lced_pkg::CS_B: begin
                w_op = lced_pkg::WOP_SUB; w_a = t1_reg; w_b = t2_reg;
            end
            lced_pkg::CS_CSXY: begin w_a = WW'(c_reg); w_b = WW'(sxy); end
            lced_pkg::CS_SXSY: begin w_a = WW'(sx);    w_b = WW'(sy);  end
            lced_pkg::CS_M: begin
                w_op = lced_pkg::WOP_SUB; w_a = t1_reg; w_b = t2_reg;
            end
            lced_pkg::CS_AB:   begin w_a = WW'(a_reg); w_b = WW'(b_reg); end
            lced_pkg::CS_MM:   begin w_a = WW'(m_reg); w_b = WW'(m_reg); end
            lced_pkg::CS_DIV: begin
                w_op = lced_pkg::WOP_DIV; w_a = t1_reg; w_b = ab_reg;
            end
            lced_pkg::CS_SQRT: begin
                w_op = lced_pkg::WOP_SQRT; w_a = t2_reg;
            end
            default: ;
        endcase
        w_req.start = (state_reg == lced_pkg::ST_CALC) && !iss_reg;
        w_req.op    = w_op;
    end

    lced_wide #(.WW(WW)) u_wide (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (w_req),
        .a       (w_a),
        .b       (w_b),
        .done    (w_done),
        .res     (w_res),
        .neg     (w_neg)
    );

    // saturate a positive full-scale peak, then apply the sign
    assign sat   = (!bneg_reg && bmag_reg == 16'h8000) ? 16'h7FFF : bmag_reg;
    assign score = bneg_reg ? (16'd0 - sat) : sat;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lced_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = lced_pkg::ST_DONE;
                    if ((s_tuser == lced_pkg::CMD_ACT && scnt_reg >= ms_reg) ||
                        (s_tuser == lced_pkg::CMD_SENT && acnt_reg >= ms_reg)) begin
                        state_next = lced_pkg::ST_EVAL;
                    end
                end
            end
            lced_pkg::ST_EVAL: begin
                if (n_min < ms_reg) begin
                    state_next = lced_pkg::ST_DONE;
                end else if (top_cur == '0) begin
                    state_next = lced_pkg::ST_FIN;
                end else begin
                    state_next = lced_pkg::ST_LAG;
                end
            end
            lced_pkg::ST_LAG: begin
                state_next = (c_cur < CW'(2)) ? lced_pkg::ST_CMP : lced_pkg::ST_ACC;
            end
            lced_pkg::ST_ACC: begin
                if (ph_reg == 2'd3 && i_reg == c_reg - CW'(1)) begin
                    state_next = lced_pkg::ST_FLUSH;
                end
            end
            lced_pkg::ST_FLUSH: state_next = lced_pkg::ST_CALC;
            lced_pkg::ST_CALC: begin
                if (iss_reg && w_done) begin
                    if (step_reg == lced_pkg::CS_SQRT) begin
                        state_next = lced_pkg::ST_CMP;
                    end else if (step_reg == lced_pkg::CS_B &&
                                 (a_reg == '0 || w_res[AW-1:0] == '0)) begin
                        state_next = lced_pkg::ST_CMP;
                    end
                end
            end
            lced_pkg::ST_CMP: begin
                state_next = (lag_reg == top_reg) ? lced_pkg::ST_FIN : lced_pkg::ST_LAG;
            end
            lced_pkg::ST_FIN: state_next = lced_pkg::ST_DONE;
            lced_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = lced_pkg::ST_IDLE;
                end
            end
            default: state_next = lced_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lced_pkg::ST_IDLE;
            wl_reg       <= 7'd64;
            ms_reg       <= 7'd8;
            ll_reg       <= 6'd8;
            thr_reg      <= 16'sd22938;
            ahead_reg    <= '0;
            shead_reg    <= '0;
            acnt_reg     <= '0;
            scnt_reg     <= '0;
            peak_reg     <= '0;
            plag_reg     <= '0;
            ep_reg       <= 1'b0;
            iss_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // load a finished result, drop one the receiver has taken
            if (state_reg == lced_pkg::ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                lced_pkg::ST_IDLE: begin
                    if (accept) begin
                        fired_reg <= 1'b0;
                        evald_reg <= (state_next == lced_pkg::ST_EVAL);
                        unique case (s_tuser)
                            lced_pkg::CMD_ACT: begin
                                if (!lim_zero) begin
                                    ahead_reg <= slot_inc(ahead_reg);
                                    if (PW'(acnt_reg) < lim) begin
                                        acnt_reg <= acnt_reg + CW'(1);
                                    end
                                end
                            end
                            lced_pkg::CMD_SENT: begin
                                if (!lim_zero) begin
                                    shead_reg <= slot_inc(shead_reg);
                                    if (PW'(scnt_reg) < lim) begin
                                        scnt_reg <= scnt_reg + CW'(1);
                                    end
                                end
                            end
                            lced_pkg::CMD_CLR: begin
                                ahead_reg <= '0;
                                shead_reg <= '0;
                                acnt_reg  <= '0;
                                scnt_reg  <= '0;
                                peak_reg  <= '0;
                                plag_reg  <= '0;
                                ep_reg    <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                    // a register write, taken only in idle, also empties windows and results
                    if (cfg_wr_en) begin
                        unique case (cfg_index)
                            lced_pkg::REG_WLEN: wl_reg  <= cfg_wdata[6:0];
                            lced_pkg::REG_MIN:  ms_reg  <= cfg_wdata[6:0];
                            lced_pkg::REG_LAG:  ll_reg  <= cfg_wdata[5:0];
                            lced_pkg::REG_THR:  thr_reg <= $signed(cfg_wdata);
                        endcase
                        ahead_reg <= '0;
                        shead_reg <= '0;
                        acnt_reg  <= '0;
                        scnt_reg  <= '0;
                        peak_reg  <= '0;
                        plag_reg  <= '0;
                        ep_reg    <= 1'b0;
                    end
                end
                lced_pkg::ST_EVAL: begin
                    if (n_min < ms_reg) begin
                        // short own window: zero the peak, keep the episode
                        peak_reg <= '0;
                        plag_reg <= '0;
                    end
                    n_reg    <= n_min;
                    top_reg  <= top_cur;
                    lag_reg  <= 6'd1;
                    bmag_reg <= '0;
                    bneg_reg <= 1'b0;
                    blag_reg <= '0;
                end
                lced_pkg::ST_LAG: begin
                    qv_reg   <= '0;
                    c_reg    <= c_cur;
                    aptr_reg <= slot_back(ahead_reg, n_reg);
                    sptr_reg <= slot_back(shead_reg, c_cur);
                    i_reg    <= '0;
                    ph_reg   <= 2'd0;
                end
                lced_pkg::ST_ACC: begin
                    ph_reg <= ph_reg + 2'd1;
                    if (ph_reg == 2'd3) begin
                        aptr_reg <= slot_inc(aptr_reg);
                        sptr_reg <= slot_inc(sptr_reg);
                        i_reg    <= i_reg + CW'(1);
                    end
                end
                lced_pkg::ST_FLUSH: begin
                    step_reg <= lced_pkg::CS_CSXX;
                    iss_reg  <= 1'b0;
                end
                lced_pkg::ST_CALC: begin
                    if (!iss_reg) begin
                        iss_reg <= 1'b1;
                    end else if (w_done) begin
                        iss_reg  <= 1'b0;
                        step_reg <= lced_pkg::calc_step_t'(step_reg + 4'd1);
                        unique case (step_reg)
                            lced_pkg::CS_CSXX, lced_pkg::CS_CSYY, lced_pkg::CS_CSXY,
                            lced_pkg::CS_MM: t1_reg <= w_res;
                            lced_pkg::CS_SXSX, lced_pkg::CS_SYSY, lced_pkg::CS_SXSY,
                            lced_pkg::CS_DIV: t2_reg <= w_res;
                            lced_pkg::CS_A:  a_reg <= w_res[AW-1:0];
                            lced_pkg::CS_B:  b_reg <= w_res[AW-1:0];
                            lced_pkg::CS_M: begin
                                m_reg   <= w_res[AW-1:0];
                                neg_reg <= w_neg;
                            end
                            lced_pkg::CS_AB:   ab_reg <= w_res;
                            lced_pkg::CS_SQRT: qv_reg <= w_res[15:0];
                            default: ;
                        endcase
                    end
                end
                lced_pkg::ST_CMP: begin
                    // strict compare: the earliest lag wins ties
                    if (qv_reg > bmag_reg) begin
                        bmag_reg <= qv_reg;
                        bneg_reg <= neg_reg;
                        blag_reg <= lag_reg;
                    end
                    lag_reg <= lag_reg + 6'd1;
                end
                lced_pkg::ST_FIN: begin
                    peak_reg  <= score;
                    plag_reg  <= blag_reg;
                    ep_reg    <= ($signed(score) >= thr_reg);
                    fired_reg <= ($signed(score) >= thr_reg) && !ep_reg;
                end
                lced_pkg::ST_DONE: begin
                    if (out_free) begin
                        m_tdata_reg  <= {7'd0, evald_reg, ep_reg, fired_reg,
                                         plag_reg, peak_reg};
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> sv/lced_checker.sv
module lced_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an accepted item keeps the input closed on the next cycle
    a_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accept");

    a_fire_in_ep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[22] || m_tdata[23])
        else $error("fired without episode");

    a_fire_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[22] || m_tdata[24])
        else $error("fired without evaluation");

    a_score_lag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] == 16'd0) || (m_tdata[21:16] != 6'd0))
        else $error("nonzero score with lag zero");

endmodule

bind lagged_correlation_episode_detector_unit lced_checker u_lced_checker (.*);

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;

    // cmd 3 is unused by the block: it must change nothing
    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int RING = 64;
    localparam int CYCLE_LIMIT = 5_000_000;

    typedef struct {
        logic [15:0] score;
        logic [5:0]  lag_val;
        logic        fired;
        logic        in_episode;
        logic        evaluated;
    } corr_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    lagged_correlation_episode_detector_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata),   // sample_value
        .s_tuser(s_tuser),   // cmd
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        // score, lag, fired, in_episode, evaluated
        .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- correlation predictor ----------------
    logic [15:0] act_ring [RING];
    logic [15:0] sen_ring [RING];
    int unsigned act_head, sen_head, act_fill, sen_fill;
    int          peak_q;
    int unsigned held_lag;
    logic        episode_on;
    int unsigned win_len, min_fill, lag_max;
    int          fire_thr;

    corr_result_t pending_results[$];
    int  mismatch_count = 0;
    bit  idling_on = 1'b1;
    int  hold_left = 0;
    int  stall_left = 0;
    longint cycle_count = 0;

    function automatic int unsigned ring_back(int unsigned head, int unsigned back);
        return (head + RING - (back % RING)) % RING;
    endfunction

    // Q1.15 correlation of activity against sentiment delayed by lag;
    // exact integer math, truncated, magnitude up to 32768
    function automatic int corr_at_lag(int unsigned n, int unsigned lag);
        logic [255:0] x, y, sx, sy, sxx, syy, sxy, cc, a, b, p, q, m, ab, rhs, lhs;
        int unsigned c, lo, hi, mid;
        logic neg;
        if (lag >= n || n - lag < 2) return 0;
        c = n - lag;
        sx = '0; sy = '0; sxx = '0; syy = '0; sxy = '0;
        for (int unsigned i = 0; i < c; i++) begin
            // offset binary: correlation is shift invariant
            x = 256'(act_ring[ring_back(act_head, n - i)] ^ 16'h8000);
            y = 256'(sen_ring[ring_back(sen_head, n - i - lag)] ^ 16'h8000);
            sx += x; sy += y;
            sxx += x * x; syy += y * y; sxy += x * y;
        end
        cc = 256'(c);
        a = cc * sxx - sx * sx;
        b = cc * syy - sy * sy;
        if (a == 0 || b == 0) return 0;
        p = cc * sxy;
        q = sx * sy;
        neg = p < q;
        m = neg ? q - p : p - q;
        ab = a * b;
        rhs = (m * m) << 30;
        lo = 0; hi = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            lhs = 256'(mid) * 256'(mid) * ab;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return neg ? -int'(lo) : int'(lo);
    endfunction

    // returns 1 when a new episode starts
    function automatic logic run_sweep();
        int unsigned n, top;
        int best, r;
        int unsigned best_l;
        logic over, fire;
        n = act_fill < sen_fill ? act_fill : sen_fill;
        if (n < min_fill) begin
            peak_q = 0; held_lag = 0;
            return 1'b0;
        end
        best = 0; best_l = 0;
        top = n == 0 ? 0 : n - 1;
        if (lag_max < top) top = lag_max;
        for (int unsigned l = 1; l <= top; l++) begin
            r = corr_at_lag(n, l);
            if ((r < 0 ? -r : r) > (best < 0 ? -best : best)) begin
                best = r; best_l = l;
            end
        end
        if (best > 32767) best = 32767;
        peak_q = best;
        held_lag = best_l & 63;
        over = best >= fire_thr;
        fire = over && !episode_on;
        episode_on = over;
        return fire;
    endfunction

    function automatic void clear_windows();
        act_head = 0; sen_head = 0; act_fill = 0; sen_fill = 0;
        peak_q = 0; held_lag = 0; episode_on = 1'b0;
    endfunction

    function automatic void predict_item(logic [1:0] cmd, logic [15:0] v);
        corr_result_t e;
        int unsigned lim;
        logic fired, evald;
        fired = 1'b0; evald = 1'b0;
        lim = win_len < RING ? win_len : RING;
        if (cmd == lced_pkg::CMD_ACT) begin
            if (lim != 0) begin
                act_ring[act_head] = v;
                act_head = (act_head + 1) % RING;
                if (act_fill < lim) act_fill++;
            end
            if (sen_fill >= min_fill) begin
                evald = 1'b1; fired = run_sweep();
            end
        end else if (cmd == lced_pkg::CMD_SENT) begin
            if (lim != 0) begin
                sen_ring[sen_head] = v;
                sen_head = (sen_head + 1) % RING;
                if (sen_fill < lim) sen_fill++;
            end
            if (act_fill >= min_fill) begin
                evald = 1'b1; fired = run_sweep();
            end
        end else if (cmd == lced_pkg::CMD_CLR) begin
            clear_windows();
        end
        e.score = peak_q[15:0];
        e.lag_val = held_lag[5:0];
        e.fired = fired;
        e.in_episode = episode_on;
        e.evaluated = evald;
        pending_results.insert(pending_results.size(), e);
    endfunction

    // ---------------- stimulus ----------------
    task automatic send_item(logic [1:0] cmd, logic [15:0] v);
        // random gap in the offered stream
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= v;
        do @(posedge aclk); while (!s_tready);
        predict_item(cmd, v);
    endtask

    // registers are written only with nothing in flight
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            lced_pkg::REG_WLEN: win_len = val[6:0];
            lced_pkg::REG_MIN:  min_fill = val[6:0];
            lced_pkg::REG_LAG:  lag_max = val[5:0];
            lced_pkg::REG_THR:  fire_thr = $signed(val);
        endcase
        clear_windows();
    endtask

    task automatic set_config(int wl, int mn, int lg, int thr);
        write_reg(lced_pkg::REG_WLEN, 16'(wl));
        write_reg(lced_pkg::REG_MIN, 16'(mn));
        write_reg(lced_pkg::REG_LAG, 16'(lg));
        write_reg(lced_pkg::REG_THR, 16'(thr));
    endtask

    // pairs of activity and delayed sentiment; junk items at noise_pct odds
    task automatic send_stream(int pairs, int delay, int noise_pct);
        logic [15:0] hist [$];
        logic [15:0] xv, yv;
        int sgn;
        sgn = $urandom_range(0, 1) ? 1 : -1;
        for (int k = 0; k < pairs; k++) begin
            xv = 16'($signed(16'($urandom_range(0, 4000))) - 2000);
            if ($urandom_range(0, 9) == 0) xv = 16'($urandom);
            hist.insert(hist.size(), xv);
            yv = hist.size() > delay ? hist[hist.size() - 1 - delay] : 16'($urandom);
            yv = 16'(sgn * $signed(yv) + int'($urandom_range(0, 600)) - 300);
            if ($urandom_range(0, 99) < noise_pct)
                send_item($urandom_range(0, 1) ? CMD_NOP : lced_pkg::CMD_CLR,
                          16'($urandom));
            if ($urandom_range(0, 99) < noise_pct)
                send_item(2'($urandom_range(0, 1)), 16'($urandom));
            send_item(lced_pkg::CMD_ACT, xv);
            send_item(lced_pkg::CMD_SENT, yv);
        end
    endtask

    // reset config: window 64, minimum 8, lag 8; extreme sample values
    task automatic test_reset_config();
        send_item(lced_pkg::CMD_SENT, 16'h8000);
        send_item(lced_pkg::CMD_ACT, 16'h7fff);
        send_item(CMD_NOP, 16'hffff);
        send_stream(9, 2, 0);
        send_item(lced_pkg::CMD_CLR, 16'h1234);
    endtask

    task automatic test_special_cases();
        // constant activity gives a zero denominator
        set_config(8, 2, 3, 100);
        repeat (4) send_item(lced_pkg::CMD_ACT, 16'h0005);
        repeat (3) send_item(lced_pkg::CMD_SENT, 16'($urandom));
        // own window shorter than the minimum after the other one fills
        set_config(8, 3, 2, 0);
        repeat (3) send_item(lced_pkg::CMD_SENT, 16'($urandom));
        send_item(lced_pkg::CMD_ACT, 16'h7fff);
        // empty lag sweep: score 0 still meets a negative threshold
        set_config(100, 1, 0, -32768);
        send_item(lced_pkg::CMD_ACT, 16'h8000);
        send_item(lced_pkg::CMD_SENT, 16'h7fff);
        send_item(lced_pkg::CMD_ACT, 16'h0001);
        // zero minimum, threshold at the largest positive score
        set_config(4, 0, 63, 32767);
        send_item(lced_pkg::CMD_SENT, 16'hffff);
        send_stream(3, 1, 0);
        // zero window length keeps both windows empty
        set_config(0, 0, 5, 0);
        send_item(lced_pkg::CMD_ACT, 16'h5555);
        send_item(lced_pkg::CMD_SENT, 16'haaaa);
    endtask

    task automatic test_backpressure();
        set_config(16, 8, 4, 20000);
        hold_left = 400;
        // cheap items: the output and the sequencer fill, then input stalls
        for (int k = 0; k < 8; k++)
            send_item(k[0] ? CMD_NOP : lced_pkg::CMD_CLR, 16'($urandom));
        send_stream(3, 1, 0);
    endtask

    task automatic test_largest_windows();
        // lag limit 63: the sweep is capped by the window fill
        set_config(20, 20, 63, 16000);
        for (int k = 0; k < 20; k++) send_item(lced_pkg::CMD_ACT, 16'($urandom));
        for (int k = 0; k < 20; k++) send_item(lced_pkg::CMD_SENT, 16'($urandom));
        send_item(lced_pkg::CMD_ACT, 16'($urandom));
    endtask

    task automatic test_random_streams();
        int wl;
        for (int ph = 0; ph < 3; ph++) begin
            wl = $urandom_range(4, 8);
            set_config(wl, $urandom_range(2, 4), $urandom_range(1, 8),
                       $urandom_range(0, 2) == 0 ? int'($urandom_range(0, 65535)) - 32768
                                                 : int'($urandom_range(16000, 30000)));
            // drop idling for the last phase
            if (ph == 2) idling_on = 1'b0;
            send_stream(7, $urandom_range(1, 4), 10);
        end
    endtask

    initial begin
        win_len = 64; min_fill = 8; lag_max = 8; fire_thr = 22938;
        clear_windows();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_config();
        test_special_cases();
        test_backpressure();
        test_largest_windows();
        test_random_streams();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // ---------------- result checking ----------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("tb: mismatch %s got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    task automatic check_result();
        corr_result_t e;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected item", m_tdata, 32'd0);
            return;
        end
        e = pending_results[0];
        pending_results.delete(0);
        if (m_tdata[15:0] != e.score)
            report_mismatch("score", 32'(m_tdata[15:0]), 32'(e.score));
        if (m_tdata[21:16] != e.lag_val)
            report_mismatch("lag", 32'(m_tdata[21:16]), 32'(e.lag_val));
        if (m_tdata[22] != e.fired)
            report_mismatch("fired", 32'(m_tdata[22]), 32'(e.fired));
        if (m_tdata[23] != e.in_episode)
            report_mismatch("in_episode", 32'(m_tdata[23]), 32'(e.in_episode));
        if (m_tdata[24] != e.evaluated)
            report_mismatch("evaluated", 32'(m_tdata[24]), 32'(e.evaluated));
    endtask

    // receiver: check, then decide ready for the next edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_result();
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

endmodule

>>> filelist.f
sv/lced_pkg.sv
sv/lced_ring.sv
sv/lced_mac.sv
sv/lced_wide.sv
sv/lagged_correlation_episode_detector_unit.sv
sv/lced_checker.sv
bench/tb.sv
